// ===== hw/rtl/b3h_pkg.sv =====
// shared types, constants and helper functions of the hash engine
// no dependencies; imported by every module of the block but b3h_ram
package b3h_pkg;

   // chunk and node flags
   localparam logic [3:0] FLAG_CHUNK_START = 4'b0001;
   localparam logic [3:0] FLAG_CHUNK_END   = 4'b0010;
   localparam logic [3:0] FLAG_PARENT      = 4'b0100;
   localparam logic [3:0] FLAG_ROOT        = 4'b1000;

   localparam logic [6:0] BLOCK_BYTES   = 7'd64;
   localparam logic [3:0] LAST_BLOCK    = 4'd15;
   localparam logic [4:0] LAST_PHASE    = 5'd27;
   localparam logic [2:0] MAX_BYTES     = 3'd4;
   localparam logic [4:0] MAX_WORDS     = 5'd16;
   localparam logic [4:0] DIGEST_RESET  = 5'd8;

   // initial chaining value
   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      logic [31:0] w;
      case (idx)
         3'd0: w = 32'h6a09e667;
         3'd1: w = 32'hbb67ae85;
         3'd2: w = 32'h3c6ef372;
         3'd3: w = 32'ha54ff53a;
         3'd4: w = 32'h510e527f;
         3'd5: w = 32'h9b05688c;
         3'd6: w = 32'h1f83d9ab;
         default: w = 32'h5be0cd19;
      endcase
      return w;
   endfunction

   // message word schedule between rounds
   function automatic logic [3:0] perm_idx(input logic [3:0] idx);
      logic [3:0] p;
      case (idx)
         4'd0: p = 4'd2;
         4'd1: p = 4'd6;
         4'd2: p = 4'd3;
         4'd3: p = 4'd10;
         4'd4: p = 4'd7;
         4'd5: p = 4'd0;
         4'd6: p = 4'd4;
         4'd7: p = 4'd13;
         4'd8: p = 4'd1;
         4'd9: p = 4'd11;
         4'd10: p = 4'd12;
         4'd11: p = 4'd5;
         4'd12: p = 4'd9;
         4'd13: p = 4'd14;
         4'd14: p = 4'd15;
         default: p = 4'd8;
      endcase
      return p;
   endfunction

   typedef enum logic [4:0] {
      S_IDLE, S_BYTE, S_BLK_RND, S_BLK_DONE, S_CH_RND, S_MERGE, S_MG_PARENT,
      S_MG_LOAD, S_MG_RND, S_PUSH, S_FIN, S_FIN_LOAD, S_FIN_RND, S_FIN_PARENT,
      S_ROOT_RND, S_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_LATCH, OP_INSERT, OP_LOAD, OP_ROUND, OP_BLK_DONE, OP_POP,
      OP_PARENT, OP_PUSH, OP_FIN_INIT, OP_OUT_NEXT, OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      SRC_BLOCK, SRC_CHUNK, SRC_NODE
   } src_type;

   typedef struct packed {
      op_type  op;
      src_type src;
      logic    root;
   } cmd_type;

   typedef struct packed {
      logic bytes_left;
      logic last;
      logic full;
      logic blk_last;
      logic stk_empty;
      logic total_even;
      logic rnd_done;
      logic out_last;
   } sts_type;

endpackage

// ===== hw/rtl/b3h_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module b3h_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 54
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/b3h_ctrl.sv =====
// sequencer of the hash engine: byte loading, compressions, merges, digest
// depends on b3h_pkg
module b3h_ctrl import b3h_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   output logic    out_valid,
   input  logic    out_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_IDLE;
      cmd.src   = SRC_NODE;
      cmd.root  = 1'b0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_BYTE;
            end
         end
         S_BYTE: begin
            if (!sts.bytes_left) begin
               if (sts.last) begin
                  cmd.op   = OP_FIN_INIT;
                  state_in = S_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end else if (sts.full) begin
               cmd.op = OP_LOAD;
               if (sts.blk_last) begin
                  cmd.src  = SRC_CHUNK;
                  state_in = S_CH_RND;
               end else begin
                  cmd.src  = SRC_BLOCK;
                  state_in = S_BLK_RND;
               end
            end else begin
               cmd.op = OP_INSERT;
            end
         end
         S_BLK_RND: begin
            cmd.op = OP_ROUND;
            if (sts.rnd_done) state_in = S_BLK_DONE;
         end
         S_BLK_DONE: begin
            cmd.op   = OP_BLK_DONE;
            state_in = S_BYTE;
         end
         S_CH_RND: begin
            cmd.op = OP_ROUND;
            if (sts.rnd_done) state_in = S_MERGE;
         end
         S_MERGE: begin
            if (sts.total_even && !sts.stk_empty) begin
               cmd.op   = OP_POP;
               state_in = S_MG_PARENT;
            end else begin
               state_in = S_PUSH;
            end
         end
         S_MG_PARENT: begin
            cmd.op   = OP_PARENT;
            state_in = S_MG_LOAD;
         end
         S_MG_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = S_MG_RND;
         end
         S_MG_RND: begin
            cmd.op = OP_ROUND;
            if (sts.rnd_done) state_in = S_MERGE;
         end
         S_PUSH: begin
            cmd.op   = OP_PUSH;
            state_in = S_BYTE;
         end
         S_FIN: begin
            if (!sts.stk_empty) begin
               cmd.op   = OP_POP;
               state_in = S_FIN_LOAD;
            end else begin
               cmd.op   = OP_LOAD;
               cmd.root = 1'b1;
               state_in = S_ROOT_RND;
            end
         end
         S_FIN_LOAD: begin
            cmd.op   = OP_LOAD;
            state_in = S_FIN_RND;
         end
         S_FIN_RND: begin
            cmd.op = OP_ROUND;
            if (sts.rnd_done) state_in = S_FIN_PARENT;
         end
         S_FIN_PARENT: begin
            cmd.op   = OP_PARENT;
            state_in = S_FIN;
         end
         S_ROOT_RND: begin
            cmd.op = OP_ROUND;
            if (sts.rnd_done) state_in = S_OUT;
         end
         S_OUT: begin
            out_valid = 1'b1;
            if (out_ready) begin
               if (sts.out_last) begin
                  cmd.op   = OP_CLEAR;
                  state_in = S_IDLE;
               end else begin
                  cmd.op = OP_OUT_NEXT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/b3h_datapath.sv =====
// datapath: block buffer, chaining value, half-mix round unit, chunk counters
// and the subtree stack; depends on b3h_pkg and b3h_ram
module b3h_datapath import b3h_pkg::*; #(
   parameter int STACK_DEPTH = 54
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [31:0] in_word,
   input  logic [2:0]  in_count,
   input  logic        in_last,
   input  logic [4:0]  digest_words,
   output logic [31:0] out_word
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

   logic [31:0] v_ff [16];
   logic [31:0] v_in [16];
   logic [31:0] buf_ff [16];
   logic [31:0] cv_ff [8];
   logic [31:0] res_w [16];
   logic [31:0] word_ff;
   logic [2:0]  cnt_ff;
   logic        last_ff;
   logic [2:0]  idx_ff;
   logic [6:0]  fill_ff;
   logic [3:0]  bd_ff;
   logic [63:0] ci_ff;
   logic [63:0] total_ff;
   logic [CNT_W-1:0] stk_ff;
   logic [63:0] pctr_ff;
   logic [6:0]  plen_ff;
   logic [3:0]  pflags_ff;
   logic [4:0]  phase_ff;
   logic [3:0]  oi_ff;
   logic [3:0]  nm1;
   logic [3:0]  start_f;
   logic [255:0] ram_wdata;
   logic [255:0] ram_rdata;
   logic         ram_we;
   logic         ram_re;
   logic [ADDR_W-1:0] ram_waddr;
   logic [ADDR_W-1:0] ram_raddr;
   logic [CNT_W-1:0]  stk_m1;

   assign start_f = (bd_ff == 4'd0) ? FLAG_CHUNK_START : 4'd0;
   assign stk_m1  = stk_ff - CNT_W'(1);

   // node output words
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         res_w[i]     = v_ff[i] ^ v_ff[i+8];
         res_w[i + 8] = v_ff[i+8] ^ cv_ff[i];
      end
   end

   // one half of the mixing function on four lanes
   always_comb begin
      logic        diag, first;
      logic [1:0]  sh;
      int          ia, ib, ic, id, mi;
      logic [31:0] a, b, c, d, x;
      for (int i = 0; i < 16; i++) v_in[i] = v_ff[i];
      diag  = phase_ff[1];
      first = !phase_ff[0];
      for (int j = 0; j < 4; j++) begin
         sh = diag ? 2'd1 : 2'd0;
         ia = j;
         ib = 4 + ((j + int'(sh)) & 3);
         ic = 8 + ((j + 2 * int'(sh)) & 3);
         id = 12 + ((j + 3 * int'(sh)) & 3);
         mi = (diag ? 8 : 0) + 2 * j + (first ? 0 : 1);
         x = buf_ff[mi];
         a = v_ff[ia] + v_ff[ib] + x;
         d = v_ff[id] ^ a;
         d = first ? {d[15:0], d[31:16]} : {d[7:0], d[31:8]};
         c = v_ff[ic] + d;
         b = v_ff[ib] ^ c;
         b = first ? {b[11:0], b[31:12]} : {b[6:0], b[31:7]};
         v_in[ia] = a;
         v_in[ib] = b;
         v_in[ic] = c;
         v_in[id] = d;
      end
   end

   // digest length clamp
   always_comb begin
      if (digest_words == 5'd0) begin
         nm1 = 4'd0;
      end else if (digest_words > MAX_WORDS) begin
         nm1 = 4'd15;
      end else begin
         nm1 = 4'(digest_words - 5'd1);
      end
   end

   // stack memory hookup
   always_comb begin
      for (int i = 0; i < 8; i++) ram_wdata[32*i +: 32] = res_w[i];
      ram_we    = (cmd.op == OP_PUSH) && (stk_ff < DEPTH_C);
      ram_waddr = stk_ff[ADDR_W-1:0];
      ram_re    = (cmd.op == OP_POP);
      ram_raddr = stk_m1[ADDR_W-1:0];
   end

   b3h_ram #(.WIDTH(256), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         bd_ff    <= '0;
         ci_ff    <= '0;
         stk_ff   <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
         phase_ff <= '0;
         oi_ff    <= '0;
      end else begin
         case (cmd.op)
            OP_LATCH: begin
               idx_ff  <= '0;
               cnt_ff  <= (in_count > MAX_BYTES) ? MAX_BYTES : in_count;
               last_ff <= in_last;
            end
            OP_INSERT: begin
               idx_ff  <= idx_ff + 3'd1;
               fill_ff <= fill_ff + 7'd1;
            end
            OP_LOAD: phase_ff <= '0;
            OP_ROUND: phase_ff <= phase_ff + 5'd1;
            OP_BLK_DONE: begin
               bd_ff   <= bd_ff + 4'd1;
               fill_ff <= '0;
            end
            OP_POP: stk_ff <= stk_m1;
            OP_PUSH: begin
               if (stk_ff < DEPTH_C) stk_ff <= stk_ff + CNT_W'(1);
               fill_ff <= '0;
               bd_ff   <= '0;
               ci_ff   <= ci_ff + 64'd1;
            end
            OP_FIN_INIT: oi_ff <= '0;
            OP_OUT_NEXT: oi_ff <= oi_ff + 4'd1;
            OP_CLEAR: begin
               fill_ff <= '0;
               bd_ff   <= '0;
               ci_ff   <= '0;
               stk_ff  <= '0;
            end
            default: ;
         endcase
      end
   end

   // buffers, chaining value and working state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) buf_ff[i] <= '0;
         for (int i = 0; i < 8; i++) cv_ff[i] <= iv_word(3'(i));
      end else begin
         case (cmd.op)
            OP_LATCH: word_ff <= in_word;
            OP_INSERT: begin
               buf_ff[fill_ff[5:2]] <= buf_ff[fill_ff[5:2]]
                  | ({24'd0, word_ff[8*idx_ff[1:0] +: 8]} << {fill_ff[1:0], 3'b000});
            end
            OP_LOAD: begin
               for (int i = 0; i < 8; i++) v_ff[i] <= cv_ff[i];
               for (int i = 0; i < 4; i++) v_ff[8+i] <= iv_word(3'(i));
               case (cmd.src)
                  SRC_BLOCK: begin
                     v_ff[12] <= ci_ff[31:0];
                     v_ff[13] <= ci_ff[63:32];
                     v_ff[14] <= 32'(BLOCK_BYTES);
                     v_ff[15] <= 32'(start_f);
                  end
                  SRC_CHUNK: begin
                     v_ff[12] <= ci_ff[31:0];
                     v_ff[13] <= ci_ff[63:32];
                     v_ff[14] <= 32'(BLOCK_BYTES);
                     v_ff[15] <= 32'(start_f | FLAG_CHUNK_END);
                     total_ff <= ci_ff + 64'd1;
                  end
                  default: begin
                     v_ff[12] <= pctr_ff[31:0];
                     v_ff[13] <= pctr_ff[63:32];
                     v_ff[14] <= 32'(plen_ff);
                     v_ff[15] <= 32'(pflags_ff | (cmd.root ? FLAG_ROOT : 4'd0));
                  end
               endcase
            end
            OP_ROUND: begin
               for (int i = 0; i < 16; i++) v_ff[i] <= v_in[i];
               if (phase_ff[1:0] == 2'd3) begin
                  for (int i = 0; i < 16; i++) buf_ff[i] <= buf_ff[perm_idx(4'(i))];
               end
            end
            OP_BLK_DONE: begin
               for (int i = 0; i < 8; i++) cv_ff[i] <= res_w[i];
               for (int i = 0; i < 16; i++) buf_ff[i] <= '0;
            end
            OP_POP: total_ff <= {1'b0, total_ff[63:1]};
            OP_PARENT: begin
               for (int i = 0; i < 8; i++) begin
                  cv_ff[i]    <= iv_word(3'(i));
                  buf_ff[i]   <= ram_rdata[32*i +: 32];
                  buf_ff[i+8] <= res_w[i];
               end
               pctr_ff   <= '0;
               plen_ff   <= BLOCK_BYTES;
               pflags_ff <= FLAG_PARENT;
            end
            OP_PUSH, OP_CLEAR: begin
               for (int i = 0; i < 8; i++) cv_ff[i] <= iv_word(3'(i));
               for (int i = 0; i < 16; i++) buf_ff[i] <= '0;
            end
            OP_FIN_INIT: begin
               pctr_ff   <= ci_ff;
               plen_ff   <= fill_ff;
               pflags_ff <= start_f | FLAG_CHUNK_END;
            end
            default: ;
         endcase
      end
   end

   // status to the sequencer
   always_comb begin
      sts.bytes_left = idx_ff < cnt_ff;
      sts.last       = last_ff;
      sts.full       = fill_ff == BLOCK_BYTES;
      sts.blk_last   = bd_ff == LAST_BLOCK;
      sts.stk_empty  = stk_ff == '0;
      sts.total_even = !total_ff[0];
      sts.rnd_done   = phase_ff == LAST_PHASE;
      sts.out_last   = oi_ff == nm1;
   end

   assign out_word = res_w[oi_ff];

endmodule

// ===== hw/rtl/blake3_hash_engine.sv =====
// BLAKE3 hash engine top level: stream ports, digest length register
// depends on b3h_pkg, b3h_ctrl, b3h_datapath
//
// Unkeyed BLAKE3 with 1 to 16 digest words. One input transaction is taken at
// a time. Each carries up to four message bytes, loaded one byte per cycle
// unless a compression comes between; the transaction is taken, its bytes are
// inserted and it is then closed. A transaction that adds a byte to a full
// 64-byte block first costs a compression: a load, the rounds of the round
// unit, which works one half of the mixing function on four lanes per cycle,
// and taking the new chaining value. Closing a 1 KiB chunk costs its
// compression, a parent merge per subtree popped from the stack and a push.
// The last transaction adds a compression per stacked subtree plus the root
// compression before the digest words stream out, one per cycle while
// rsp_tready is high. The stack memory needs no clearing pass after reset.
module blake3_hash_engine import b3h_pkg::*; #(
   parameter int STACK_DEPTH = 54
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // data_word[31:0], byte_count[34:32], zero pad
   input  logic        req_tlast,  // last_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // digest_word[31:0]
   output logic        rsp_tlast,  // last_word
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   cmd_type    cmd;
   sts_type    sts;
   logic [4:0] dw_ff;

   // digest length register
   always_ff @(posedge clock) begin
      if (reset) begin
         dw_ff <= DIGEST_RESET;
      end else if (csr_we) begin
         dw_ff <= csr_wdata;
      end
   end

   b3h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   b3h_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .in_word      (req_tdata[31:0]),
      .in_count     (req_tdata[34:32]),
      .in_last      (req_tlast),
      .digest_words (dw_ff),
      .out_word     (rsp_tdata)
   );

   assign rsp_tlast = sts.out_last;

   // input and output sides never open together
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && req_tready))
      else $error("input ready while digest pending");

   // one transaction at a time
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction taken while busy");

   // after the final digest word the engine is free again
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("engine not idle after digest");

endmodule
